### sv/tfd_pkg.sv
`timescale 1ns / 1ps

package tfd_pkg;

    // Default store depth in bytes
    localparam int DEF_BUFFER_BYTES = 64;

    // CRC-8 generator polynomial, start value zero
    localparam logic [7:0] CRC_POLY = 8'hD5;

    // Address register value after reset
    localparam logic [7:0] ADDR_RESET = 8'hEA;

    // Width of the reported byte position
    localparam int POS_W = 6;

    // Result status codes
    localparam logic ST_GOOD    = 1'b0;
    localparam logic ST_CRC_ERR = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;   // input transaction taken this cycle
        logic rd;       // read the next payload byte from the store
        logic ld_data;  // load a payload result into the output register
        logic ld_err;   // load the CRC error result into the output register
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic done;     // incoming byte completes the frame
        logic crc_ok;   // received CRC matches the running check
        logic out_free; // output register can take a new result
        logic last_p;   // current read position is the final payload byte
    } t_stat;

    // One byte step of the CRC-8, MSB first
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

### sv/tfd_ctrl.sv
`timescale 1ns / 1ps

module tfd_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  tfd_pkg::t_stat i_stat,
    output tfd_pkg::t_cmd  o_cmd
);

    typedef enum logic [1:0] {
        S_RX,
        S_ERR,
        S_RD,
        S_LD
    } t_state;

    t_state r_state;
    t_state n_state;

    // Take bytes only while receiving
    assign o_ready = (r_state == S_RX);

    // Decode commands from the current state
    always_comb begin
        o_cmd         = '0;
        o_cmd.accept  = (r_state == S_RX) && i_valid;
        o_cmd.rd      = (r_state == S_RD);
        o_cmd.ld_data = (r_state == S_LD) && i_stat.out_free;
        o_cmd.ld_err  = (r_state == S_ERR) && i_stat.out_free;
    end

    // Next state: receive, then replay or report an error
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_RX: begin
                if (i_valid && i_stat.done) begin
                    n_state = i_stat.crc_ok ? S_RD : S_ERR;
                end
            end
            S_ERR: begin
                if (i_stat.out_free) begin
                    n_state = S_RX;
                end
            end
            S_RD: begin
                n_state = S_LD;
            end
            S_LD: begin
                if (i_stat.out_free) begin
                    n_state = i_stat.last_p ? S_RX : S_RD;
                end
            end
            default: begin
                n_state = S_RX;
            end
        endcase
    end

    // Hold state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RX;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

### sv/tfd_dp.sv
`timescale 1ns / 1ps

module tfd_dp #(
    parameter int BUFFER_BYTES = tfd_pkg::DEF_BUFFER_BYTES
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_wr_en,
    input  logic [7:0]               i_cfg_wr_data,
    input  logic [7:0]               i_data_byte,
    input  tfd_pkg::t_cmd            i_cmd,
    output tfd_pkg::t_stat           o_stat,
    input  logic                     i_ready,
    output logic                     o_valid,
    output logic [7:0]               o_out_byte,
    output logic [tfd_pkg::POS_W-1:0] o_byte_position,
    output logic                     o_status,
    output logic                     o_last
);

    localparam int IW = $clog2(BUFFER_BYTES);
    localparam int CW = $clog2(BUFFER_BYTES + 1);
    localparam logic [8:0] MAX_LEN = 9'(BUFFER_BYTES - 2);
    localparam logic [CW-1:0] FULL = CW'(BUFFER_BYTES);

    logic [7:0]    mem [BUFFER_BYTES];
    logic [7:0]    r_rdata;
    logic [7:0]    r_addr;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [7:0]    r_crc;
    logic [7:0]    r_len;
    logic [IW-1:0] r_p;
    logic          hit_addr;
    logic          bad_len;
    logic          full;
    logic          store_en;
    logic          done;

    // Classify the incoming byte
    assign hit_addr = (r_count != '0) || (i_data_byte == r_addr);
    assign bad_len  = (r_count == CW'(1)) &&
                      ((i_data_byte < 8'd2) || ({1'b0, i_data_byte} > MAX_LEN));
    assign full     = (r_count >= FULL);
    assign store_en = hit_addr && !bad_len && !full;
    assign n_count  = r_count + CW'(1);
    assign done     = store_en && (n_count > CW'(4)) &&
                      (({1'b0, r_len} + 9'd2) == 9'(n_count));

    assign o_stat.done     = done;
    assign o_stat.crc_ok   = (r_crc == i_data_byte);
    assign o_stat.out_free = !o_valid || i_ready;
    assign o_stat.last_p   = (r_p == IW'(r_len - 8'd2));

    // Hold the device address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= tfd_pkg::ADDR_RESET;
        end else if (i_cfg_wr_en) begin
            r_addr <= i_cfg_wr_data;
        end
    end

    // Advance the byte count and running check
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= '0;
        end else if (i_cmd.accept) begin
            if (bad_len || full || done) begin
                r_count <= '0;
                r_crc   <= '0;
            end else if (store_en) begin
                r_count <= n_count;
                if (r_count >= CW'(2)) begin
                    r_crc <= tfd_pkg::crc8_update(r_crc, i_data_byte);
                end
            end
        end
    end

    // Capture the length byte
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && store_en && (r_count == CW'(1))) begin
            r_len <= i_data_byte;
        end
    end

    // Write the frame store and read back for replay
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && store_en) begin
            mem[r_count[IW-1:0]] <= i_data_byte;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem[r_p + IW'(2)];
        end
    end

    // Step the replay position
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && done) begin
            r_p <= '0;
        end else if (i_cmd.ld_data) begin
            r_p <= r_p + IW'(1);
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_cmd.ld_data || i_cmd.ld_err) begin
            o_valid <= 1'b1;
        end else if (i_ready) begin
            o_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_data) begin
            o_out_byte      <= r_rdata;
            o_byte_position <= tfd_pkg::POS_W'(r_p);
            o_status        <= tfd_pkg::ST_GOOD;
            o_last          <= o_stat.last_p;
        end else if (i_cmd.ld_err) begin
            o_out_byte      <= '0;
            o_byte_position <= '0;
            o_status        <= tfd_pkg::ST_CRC_ERR;
            o_last          <= 1'b1;
        end
    end

endmodule

### sv/telemetry_frame_deframer.sv
// After the CRC byte is taken, a good frame's first result passes the store read, then the output load.
// Throughput: one received byte per cycle while a frame is being collected; a good frame
// then replays byte by byte (store read, then output load), blocking input.
// A CRC error is reported from the error state. Output backpressure stretches the replay.
// Reset (synchronous, active low) empties the frame and sets the address to 0xEA.
`timescale 1ns / 1ps

module telemetry_frame_deframer #(
    parameter int BUFFER_BYTES = tfd_pkg::DEF_BUFFER_BYTES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [7:0]                i_cfg_wr_data,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_data_byte,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [7:0]                o_out_byte,
    output logic [tfd_pkg::POS_W-1:0] o_byte_position,
    output logic                      o_status,
    output logic                      o_last
);

    tfd_pkg::t_cmd  cmd;
    tfd_pkg::t_stat stat;

    // Sequence reception and replay
    tfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    // Store, check and output register
    tfd_dp #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_data_byte     (i_data_byte),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_out_byte      (o_out_byte),
        .o_byte_position (o_byte_position),
        .o_status        (o_status),
        .o_last          (o_last)
    );

endmodule

### test/telemetry_frame_deframer_tb.sv
`timescale 1ns / 1ps

module telemetry_frame_deframer_tb;

    localparam int SETTLE_CYCLES = 10;
    localparam int HOLD_CYCLES   = 200;
    localparam int RUN_LIMIT_NS  = 2000000;

    // Scoreboard: rebuilds frames from accepted bytes and holds the expected replay
    class deframe_scoreboard;
        localparam int DEPTH = tfd_pkg::DEF_BUFFER_BYTES;

        typedef struct {
            logic [7:0]                data;
            logic [tfd_pkg::POS_W-1:0] pos;
            logic                      status;
            logic                      last;
        } t_frame_out;

        logic [7:0] dev_addr;
        logic [7:0] frame_bytes [DEPTH];
        int         held;
        logic [7:0] crc_acc;
        t_frame_out replay_q [$];
        int         mismatches;

        function new();
            dev_addr   = tfd_pkg::ADDR_RESET;
            held       = 0;
            crc_acc    = 8'h00;
            mismatches = 0;
            foreach (frame_bytes[k]) frame_bytes[k] = 8'h00;
        endfunction

        // CRC-8, MSB first, one byte
        static function logic [7:0] crc_step(logic [7:0] crc, logic [7:0] b);
            logic [7:0] c;
            logic       fb;
            c = crc ^ b;
            for (int i = 0; i < 8; i++) begin
                fb = c[7];
                c  = c << 1;
                if (fb) begin
                    c = c ^ tfd_pkg::CRC_POLY;
                end
            end
            return c;
        endfunction

        function void set_address(logic [7:0] a);
            dev_addr = a;
        endfunction

        function int pending();
            return replay_q.size();
        endfunction

        // Advance the frame state by one accepted byte, queue any replay it causes
        function void note_rx_byte(logic [7:0] b);
            int                        len;
            int                        n;
            logic                      good;
            t_frame_out                r;
            logic [tfd_pkg::POS_W-1:0] posv;
            // drop bytes that do not open a frame
            if (held == 0 && b != dev_addr) begin
                return;
            end
            // drop the frame on an out-of-range length
            if (held == 1 && (b < 2 || b > DEPTH - 2)) begin
                held    = 0;
                crc_acc = 8'h00;
                return;
            end
            // drop the byte and return to idle when the store is full
            if (held >= DEPTH) begin
                held    = 0;
                crc_acc = 8'h00;
                return;
            end
            frame_bytes[held] = b;
            if (held == 0) begin
                crc_acc = 8'h00;
            end
            held = held + 1;
            len  = int'(frame_bytes[1]);
            // frame end: compare the CRC and queue the replay or the error
            if (held > 4 && len + 2 == held) begin
                good    = (crc_acc == b);
                held    = 0;
                crc_acc = 8'h00;
                if (!good) begin
                    r.data   = 8'h00;
                    r.pos    = '0;
                    r.status = tfd_pkg::ST_CRC_ERR;
                    r.last   = 1'b1;
                    replay_q.push_back(r);
                end else begin
                    n = len - 1;
                    for (int p = 0; p < n; p++) begin
                        posv     = p[tfd_pkg::POS_W-1:0];
                        r.data   = frame_bytes[(2 + p) % DEPTH];
                        r.pos    = posv;
                        r.status = tfd_pkg::ST_GOOD;
                        r.last   = (p + 1 == n);
                        replay_q.push_back(r);
                    end
                end
                return;
            end
            if (held - 1 >= 2) begin
                crc_acc = crc_step(crc_acc, b);
            end
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // Compare one output transaction with the oldest queued replay entry
        task check_frame_output(logic [7:0] data, logic [tfd_pkg::POS_W-1:0] pos,
                                logic st, logic lst);
            t_frame_out want;
            if (replay_q.size() == 0) begin
                report_mismatch($sformatf("unexpected output byte %02h pos %0d status %0b",
                                          data, pos, st));
                return;
            end
            want = replay_q.pop_front();
            if (data !== want.data) begin
                report_mismatch($sformatf("out_byte %02h, want %02h", data, want.data));
            end
            if (pos !== want.pos) begin
                report_mismatch($sformatf("byte_position %0d, want %0d", pos, want.pos));
            end
            if (st !== want.status) begin
                report_mismatch($sformatf("status %0b, want %0b", st, want.status));
            end
            if (lst !== want.last) begin
                report_mismatch($sformatf("last %0b, want %0b", lst, want.last));
            end
        endtask
    endclass

    logic                      i_clk         = 1'b0;
    logic                      i_rst_n       = 1'b0;
    logic                      i_cfg_wr_en   = 1'b0;
    logic [7:0]                i_cfg_wr_data = 8'h00;
    logic                      i_valid       = 1'b0;
    logic                      o_ready;
    logic [7:0]                i_data_byte   = 8'h00;
    logic                      o_valid;
    logic                      i_ready       = 1'b0;
    logic [7:0]                o_out_byte;
    logic [tfd_pkg::POS_W-1:0] o_byte_position;
    logic                      o_status;
    logic                      o_last;

    deframe_scoreboard sb = new();

    bit tx_idle_on = 1'b1;
    bit rx_idle_on = 1'b1;
    bit long_hold  = 1'b0;
    int bytes_sent = 0;

    telemetry_frame_deframer DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_data_byte     (i_data_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_out_byte      (o_out_byte),
        .o_byte_position (o_byte_position),
        .o_status        (o_status),
        .o_last          (o_last)
    );

    always #1 i_clk = ~i_clk;

    // Receiver: random stall bursts, one long hold on request
    always begin
        @(negedge i_clk);
        if (long_hold) begin
            i_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(negedge i_clk);
            long_hold = 1'b0;
        end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
            i_ready <= 1'b0;
            repeat ($urandom_range(1, 3) - 1) @(negedge i_clk);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Check every output transaction
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_frame_output(o_out_byte, o_byte_position, o_status, o_last);
        end
    end

    task automatic idle_tx(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
    endtask

    // Offer one byte and hold it until the transaction completes
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        sb.note_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_item(input logic [7:0] b);
        if (tx_idle_on && $urandom_range(0, 3) == 0) begin
            idle_tx($urandom_range(1, 3));
        end
        send_byte(b);
    endtask

    // Address, length, type and payload of random content, then the CRC
    task automatic send_frame(input logic [7:0] len, input bit bad_crc);
        logic [7:0] crc;
        logic [7:0] b;
        crc = 8'h00;
        send_item(sb.dev_addr);
        send_item(len);
        for (int k = 0; k < len - 1; k++) begin
            b   = 8'($urandom_range(0, 255));
            crc = deframe_scoreboard::crc_step(crc, b);
            send_item(b);
        end
        if (bad_crc) begin
            crc = crc ^ (8'h01 << $urandom_range(0, 7));
        end
        send_item(crc);
    endtask

    // Mostly well-formed frames, some bad CRCs, noise, bad lengths and cut frames
    task automatic run_random_traffic(input int byte_budget);
        int stop_at;
        int kind;
        int n;
        stop_at = bytes_sent + byte_budget;
        while (bytes_sent < stop_at) begin
            kind = $urandom_range(0, 11);
            if (kind <= 6) begin
                send_frame(8'($urandom_range(3, 12)), 1'b0);
            end else if (kind == 7) begin
                send_frame(8'($urandom_range(3, 12)), 1'b1);
            end else if (kind == 8) begin
                n = $urandom_range(1, 3);
                repeat (n) send_item(8'($urandom_range(0, 255)));
            end else if (kind == 9) begin
                send_item(sb.dev_addr);
                if ($urandom_range(0, 1) == 0) begin
                    send_item(8'($urandom_range(0, 1)));
                end else begin
                    send_item(8'($urandom_range(63, 255)));
                end
            end else if (kind == 10) begin
                send_item(sb.dev_addr);
                send_item(8'($urandom_range(3, 12)));
                n = $urandom_range(1, 3);
                repeat (n) send_item(8'($urandom_range(0, 255)));
            end else begin
                send_frame(8'd3, 1'($urandom_range(0, 1)));
            end
        end
    endtask

    // Push zeros until any partial frame is completed or dropped
    task automatic flush_partial();
        while (sb.held != 0) begin
            send_item(8'h00);
        end
    endtask

    // Stop offering and wait for every queued result to arrive
    task automatic wait_drained();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_address(input logic [7:0] a);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= a;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.set_address(a);
    endtask

    initial begin
        #(RUN_LIMIT_NS);
        $display("telemetry_frame_deframer test failed");
        $finish;
    end

    initial begin
        logic [7:0] crc;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wrong address while idle
        send_item(8'h00);
        send_item(8'hFF);
        // Lengths out of range: 0, 1, one above the limit
        send_item(tfd_pkg::ADDR_RESET);
        send_item(8'd0);
        send_item(tfd_pkg::ADDR_RESET);
        send_item(8'd1);
        send_item(tfd_pkg::ADDR_RESET);
        send_item(8'd63);
        // Shortest good frame with extreme type and payload
        crc = deframe_scoreboard::crc_step(deframe_scoreboard::crc_step(8'h00, 8'hFF), 8'h00);
        send_item(tfd_pkg::ADDR_RESET);
        send_item(8'd3);
        send_item(8'hFF);
        send_item(8'h00);
        send_item(crc);
        // Shortest frame with a corrupted CRC
        crc = deframe_scoreboard::crc_step(deframe_scoreboard::crc_step(8'h00, 8'h00), 8'hFF);
        send_item(tfd_pkg::ADDR_RESET);
        send_item(8'd3);
        send_item(8'h00);
        send_item(8'hFF);
        send_item(crc ^ 8'h80);

        // Address zero, longest frame
        wait_drained();
        write_address(8'h00);
        send_frame(8'd62, 1'b0);
        run_random_traffic(8);

        // Address all ones, length-two frame fills the store and drops
        flush_partial();
        wait_drained();
        write_address(8'hFF);
        send_frame(8'd2, 1'b0);
        repeat (61) send_item(8'($urandom_range(0, 255)));
        run_random_traffic(8);

        // Random address; stall the output long enough to back up the input
        flush_partial();
        wait_drained();
        write_address(8'($urandom_range(0, 255)));
        long_hold = 1'b1;
        send_frame(8'd20, 1'b0);
        send_frame(8'd8, 1'b0);
        run_random_traffic(4);

        // Final stretch at full rate on both sides
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        run_random_traffic(16);

        wait_drained();
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("telemetry_frame_deframer test passed");
        end else begin
            $display("telemetry_frame_deframer test failed");
        end
        $finish;
    end

endmodule
